// File: rtl/fbfl_pkg.sv
// Package for the fixed block free list allocator.
// Holds widths, command and status codes and the size rounding helper.
// No dependencies.
package fbfl_pkg;

    localparam int MAX_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int REQ_BYTES_W = 16;
    localparam int BYTES_W    = REQ_BYTES_W + 1;
    localparam int SPAN_W     = CNT_W + BYTES_W;
    localparam int END_W      = ADDR_W + 1;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    localparam logic [BYTES_W-1:0] ROUND_ADD  = BYTES_W'(7);
    localparam logic [BYTES_W-1:0] ROUND_MASK = ~BYTES_W'(7);

    function automatic logic [BYTES_W-1:0] round_bytes(input logic [REQ_BYTES_W-1:0] b);
        logic [BYTES_W-1:0] sum;
        sum = {1'b0, b} + ROUND_ADD;
        return sum & ROUND_MASK;
    endfunction

endpackage

// File: rtl/fbfl_ifs.sv
// Request and response channel interfaces of the block allocator.
// Depends on fbfl_pkg for field widths.
interface fbfl_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbfl_pkg::CMD_W-1:0]    cmd;
    logic [fbfl_pkg::ADDR_W-1:0]   free_address;

    modport source (output valid, output cmd, output free_address, input ready);
    modport sink   (input valid, input cmd, input free_address, output ready);
endinterface

interface fbfl_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [fbfl_pkg::STATUS_W-1:0]   status;
    logic [fbfl_pkg::ADDR_W-1:0]     block_address;
    logic [fbfl_pkg::CNT_W-1:0]      blocks_free;

    modport source (output valid, output status, output block_address, output blocks_free,
                    input ready);
    modport sink   (input valid, input status, input block_address, input blocks_free,
                    output ready);
endinterface

// File: rtl/fixed_block_free_list_allocator_core.sv
// Fixed size block pool allocator: a LIFO stack of free block addresses in one RAM.
// One command is in work at a time. An alloc that pops passes through accept, stack
// RAM read and result load. An alloc on an empty stack, a free, a destroy and an init
// with zero size or zero count go from accept straight to the result load. For a
// valid init the fill writes one stack entry per cycle, then the pool end is formed.
// The result shows up in the cycle in which the input turns ready again. A new command
// is accepted while the previous result still waits in the output register; its own
// result then holds until that one is taken. The stack RAM needs no clearing after
// reset: only entries written by init or free are ever read.
// Depends on fbfl_pkg, fbfl_ifs and fbfl_stack_ram.
module fixed_block_free_list_allocator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    fbfl_req_if.sink                             i_req,
    fbfl_rsp_if.source                           o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALOAD = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_SPAN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]                          r_state, n_state;

    logic [fbfl_pkg::ADDR_W-1:0]         r_cfg_base;
    logic [fbfl_pkg::REQ_BYTES_W-1:0]    r_cfg_bytes;
    logic [fbfl_pkg::CNT_W-1:0]          r_cfg_count;

    logic [fbfl_pkg::CNT_W-1:0]          r_top;
    logic [fbfl_pkg::CNT_W-1:0]          r_count;
    logic [fbfl_pkg::BYTES_W-1:0]        r_bytes;
    logic [fbfl_pkg::ADDR_W-1:0]         r_base;
    logic [fbfl_pkg::END_W-1:0]          r_end;
    logic [fbfl_pkg::SPAN_W-1:0]         r_span;
    logic [fbfl_pkg::CNT_W-1:0]          r_idx;
    logic [fbfl_pkg::ADDR_W-1:0]         r_fill;

    logic [fbfl_pkg::STATUS_W-1:0]       r_res_status;
    logic [fbfl_pkg::ADDR_W-1:0]         r_res_addr;

    logic                                r_out_valid;
    logic [fbfl_pkg::STATUS_W-1:0]       r_out_status;
    logic [fbfl_pkg::ADDR_W-1:0]         r_out_addr;
    logic [fbfl_pkg::CNT_W-1:0]          r_out_free;

    logic                                accept;
    logic                                is_alloc, is_free, is_init;
    logic                                top_zero;
    logic                                free_null, free_outside, free_full, free_ok;
    logic                                init_ok;
    logic [fbfl_pkg::CNT_W-1:0]          sat_count;
    logic [fbfl_pkg::CNT_W-1:0]          top_dec;
    logic [fbfl_pkg::END_W-1:0]          addr_ext;
    logic                                fill_last;
    logic                                emit_go;

    logic                                ram_we;
    logic [fbfl_pkg::IDX_W-1:0]          ram_waddr;
    logic [fbfl_pkg::ADDR_W-1:0]         ram_wdata;
    logic                                ram_re;
    logic [fbfl_pkg::ADDR_W-1:0]         ram_rdata;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign is_alloc    = (i_req.cmd == fbfl_pkg::CMD_ALLOC);
    assign is_free     = (i_req.cmd == fbfl_pkg::CMD_FREE);
    assign is_init     = (i_req.cmd == fbfl_pkg::CMD_INIT);

    assign top_zero     = (r_top == '0);
    assign top_dec      = r_top - fbfl_pkg::CNT_W'(1);
    assign addr_ext     = {1'b0, i_req.free_address};
    assign free_null    = (i_req.free_address == '0);
    assign free_outside = (i_req.free_address < r_base) || (addr_ext >= r_end);
    assign free_full    = (r_top >= r_count);
    assign free_ok      = !free_null && !free_outside && !free_full;
    assign init_ok      = (r_cfg_bytes != '0) && (r_cfg_count != '0);
    assign sat_count    = (r_cfg_count > fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS))
                        ? fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS) : r_cfg_count;
    assign fill_last    = (r_idx == r_count - fbfl_pkg::CNT_W'(1));
    assign emit_go      = (r_state == S_EMIT) && (!r_out_valid || o_rsp.ready);

    // stack RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_top[fbfl_pkg::IDX_W-1:0];
        ram_wdata = i_req.free_address;
        if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx[fbfl_pkg::IDX_W-1:0];
            ram_wdata = r_fill;
        end else if (accept && is_free && free_ok) begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = accept && is_alloc && !top_zero;

    fbfl_stack_ram #(
        .DEPTH (fbfl_pkg::MAX_BLOCKS),
        .WIDTH (fbfl_pkg::ADDR_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (top_dec[fbfl_pkg::IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (is_alloc && !top_zero) begin
                        n_state = S_ALOAD;
                    end else if (is_init && init_ok) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_ALOAD: n_state = S_EMIT;
            S_FILL: begin
                if (fill_last) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: n_state = S_EMIT;
            S_EMIT: begin
                if (emit_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_bytes <= fbfl_pkg::REQ_BYTES_W'(8);
            r_cfg_count <= fbfl_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fbfl_pkg::CFG_BASE:  r_cfg_base  <= i_cfg_data[fbfl_pkg::ADDR_W-1:0];
                fbfl_pkg::CFG_BYTES: r_cfg_bytes <= i_cfg_data[fbfl_pkg::REQ_BYTES_W-1:0];
                fbfl_pkg::CFG_COUNT: r_cfg_count <= i_cfg_data[fbfl_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // pool state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_count <= '0;
            r_bytes <= '0;
            r_base  <= '0;
            r_end   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                case (i_req.cmd)
                    fbfl_pkg::CMD_ALLOC: begin
                        if (!top_zero) begin
                            r_top <= top_dec;
                        end
                    end
                    fbfl_pkg::CMD_FREE: begin
                        if (free_ok) begin
                            r_top <= r_top + fbfl_pkg::CNT_W'(1);
                        end
                    end
                    fbfl_pkg::CMD_INIT: begin
                        if (init_ok) begin
                            r_base  <= r_cfg_base;
                            r_bytes <= fbfl_pkg::round_bytes(r_cfg_bytes);
                            r_count <= sat_count;
                        end
                    end
                    fbfl_pkg::CMD_DESTROY: begin
                        r_count <= '0;
                        r_top   <= '0;
                        r_end   <= {1'b0, r_base};
                    end
                    default: ;
                endcase
            end
            if (r_state == S_SPAN) begin
                r_end <= {1'b0, r_base} + fbfl_pkg::END_W'(r_span);
                r_top <= r_count;
            end
        end
    end

    // fill walk and result capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx        <= '0;
            r_fill       <= r_cfg_base;
            r_res_addr   <= '0;
            r_res_status <= fbfl_pkg::ST_OK;
            case (i_req.cmd)
                fbfl_pkg::CMD_ALLOC: begin
                    if (top_zero) begin
                        r_res_status <= fbfl_pkg::ST_EMPTY;
                    end
                end
                fbfl_pkg::CMD_FREE: begin
                    if (free_null) begin
                        r_res_status <= fbfl_pkg::ST_NULL;
                    end else if (free_outside) begin
                        r_res_status <= fbfl_pkg::ST_OUTSIDE;
                    end else if (free_full) begin
                        r_res_status <= fbfl_pkg::ST_FULL;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == S_FILL) begin
            r_idx  <= r_idx + fbfl_pkg::CNT_W'(1);
            r_fill <= r_fill + fbfl_pkg::ADDR_W'(r_bytes);
            r_span <= fbfl_pkg::SPAN_W'(r_count) * fbfl_pkg::SPAN_W'(r_bytes);
        end
        if (r_state == S_ALOAD) begin
            r_res_addr <= ram_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_free   <= r_top;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.blocks_free   = r_out_free;

endmodule

// File: rtl/fbfl_stack_ram.sv
// Simple dual port RAM, one write and one registered read port.
// Holds the free address stack; no dependencies.
module fbfl_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
